### sv/hbg_pkg.sv
// Shared constants, types and the CORDIC angle table for the hydrogen bond geometry test.
package hbg_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS    = 16;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;
  localparam int CFRAC        = 30;
  localparam int CORDIC_STEPS = 24;

  // Field and datapath widths
  localparam int COORD_W    = 26;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * DIFF_W;
  localparam int DOT_W      = SQ_W + 1;
  localparam int ID_W       = 32;
  localparam int DCUT_W     = 20;
  localparam int ACUT_W     = 23;
  localparam int RU_W       = 20;
  localparam int RV_W       = SQ_W / 2;
  localparam int RW_W       = 22;
  localparam int ANG_W      = 23;
  localparam int DEN_W      = RU_W + RV_W;
  localparam int CM_W       = CFRAC + 1;
  localparam int S_RAD_W    = 2 * CM_W;
  localparam int XYW        = CM_W + 3;
  localparam int ZW         = 33;
  localparam int ANGZ_W     = 32;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_CUTOFF  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_CUTOFF = 2'd1;
  localparam logic [DCUT_W-1:0] DIST_CUTOFF_RST  = 20'd229376;
  localparam logic [ACUT_W-1:0] ANGLE_CUTOFF_RST = 23'd1966080;

  // Front pipeline depth and default queue depth
  localparam int FRONT_LAT  = 3;
  localparam int FIFO_DEPTH = 8;

  // Candidate that passed the distance and zero-vector checks
  typedef struct packed {
    logic [SQ_W-1:0]         usq;
    logic [SQ_W-1:0]         vsq;
    logic [SQ_W-1:0]         wsq;
    logic signed [DOT_W-1:0] dot;
    logic [ID_W-1:0]         did;
    logic [ID_W-1:0]         hid;
    logic [ID_W-1:0]         aid;
  } hbg_item_t;

  // Values carried alongside the angle computation
  typedef struct packed {
    logic [ID_W-1:0] did;
    logic [ID_W-1:0] hid;
    logic [ID_W-1:0] aid;
    logic            neg;
    logic [RU_W-1:0] ru;
    logic [RW_W-1:0] rw;
  } hbg_side_t;

  // atan(2^-i) in degrees, ANG_FRAC fractional bits
  function automatic logic signed [ZW-1:0] atan_deg(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:       r = 33'sd754974720;
      1:       r = 33'sd445687602;
      2:       r = 33'sd235489088;
      3:       r = 33'sd119537938;
      4:       r = 33'sd60000934;
      5:       r = 33'sd30029717;
      6:       r = 33'sd15018523;
      7:       r = 33'sd7509720;
      8:       r = 33'sd3754917;
      9:       r = 33'sd1877466;
      10:      r = 33'sd938734;
      11:      r = 33'sd469367;
      12:      r = 33'sd234684;
      13:      r = 33'sd117342;
      14:      r = 33'sd58671;
      15:      r = 33'sd29335;
      16:      r = 33'sd14668;
      17:      r = 33'sd7334;
      18:      r = 33'sd3667;
      19:      r = 33'sd1833;
      20:      r = 33'sd917;
      21:      r = 33'sd458;
      22:      r = 33'sd229;
      23:      r = 33'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### sv/hbg_isqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage, several lanes.
module hbg_isqrt #(
  parameter int IN_W   = 54,
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [LANES-1:0][IN_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [LANES-1:0][IN_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int STAGES = IN_W / 2;
  localparam int ROOT_W = STAGES;
  localparam int REM_W  = ROOT_W + 2;

  logic [STAGES-1:0]               vld_p, vld_q;
  logic [LANES-1:0][IN_W-1:0]      rad_p  [STAGES];
  logic [LANES-1:0][IN_W-1:0]      rad_q  [STAGES];
  logic [LANES-1:0][REM_W-1:0]     rem_p  [STAGES];
  logic [LANES-1:0][REM_W-1:0]     rem_d  [STAGES];
  logic [LANES-1:0][REM_W-1:0]     rem_q  [STAGES];
  logic [LANES-1:0][ROOT_W-1:0]    root_p [STAGES];
  logic [LANES-1:0][ROOT_W-1:0]    root_d [STAGES];
  logic [LANES-1:0][ROOT_W-1:0]    root_q [STAGES];
  logic [LANES-1:0][REM_W-1:0]     cur    [STAGES];
  logic [LANES-1:0][REM_W-1:0]     trial  [STAGES];
  logic [SIDE_W-1:0]               side_p [STAGES];
  logic [SIDE_W-1:0]               side_q [STAGES];

  // stage inputs: first stage from ports, then from the previous stage
  always_comb begin
    vld_p[0]  = valid_i;
    rad_p[0]  = rad_i;
    rem_p[0]  = '0;
    root_p[0] = '0;
    side_p[0] = side_i;
    for (int s = 1; s < STAGES; s++) begin
      vld_p[s]  = vld_q[s-1];
      rad_p[s]  = rad_q[s-1];
      rem_p[s]  = rem_q[s-1];
      root_p[s] = root_q[s-1];
      side_p[s] = side_q[s-1];
    end
  end

  // one trial subtraction per stage and lane
  always_comb begin
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        cur[s][l]   = {rem_p[s][l][REM_W-3:0], rad_p[s][l][IN_W-1-2*s -: 2]};
        trial[s][l] = {root_p[s][l], 2'b01};
        if (cur[s][l] >= trial[s][l]) begin
          rem_d[s][l]  = cur[s][l] - trial[s][l];
          root_d[s][l] = {root_p[s][l][ROOT_W-2:0], 1'b1};
        end else begin
          rem_d[s][l]  = cur[s][l];
          root_d[s][l] = {root_p[s][l][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_p;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < STAGES; s++) begin
      rad_q[s]  <= rad_p[s];
      rem_q[s]  <= rem_d[s];
      root_q[s] <= root_d[s];
      side_q[s] <= side_p[s];
    end
  end

  assign valid_o = vld_q[STAGES-1];
  assign root_o  = root_q[STAGES-1];
  assign side_o  = side_q[STAGES-1];

endmodule

### sv/hbg_front.sv
// Front end: vector differences, squared lengths, dot product and distance/zero classification.
module hbg_front (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    donor_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    donor_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    donor_z_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    hydrogen_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    hydrogen_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    hydrogen_z_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    acceptor_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    acceptor_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]    acceptor_z_i,
  input  logic [hbg_pkg::ID_W-1:0]              donor_id_i,
  input  logic [hbg_pkg::ID_W-1:0]              hydrogen_id_i,
  input  logic [hbg_pkg::ID_W-1:0]              acceptor_id_i,
  input  logic [hbg_pkg::DCUT_W-1:0]            dist_cutoff_i,
  output logic                                  push_o,
  output hbg_pkg::hbg_item_t                    item_o
);
  import hbg_pkg::*;

  logic signed [COORD_W-1:0] d_c [3];
  logic signed [COORD_W-1:0] h_c [3];
  logic signed [COORD_W-1:0] a_c [3];

  logic                      s1_vld_q, s2_vld_q, push_q;
  logic signed [DIFF_W-1:0]  u_q [3];
  logic signed [DIFF_W-1:0]  v_q [3];
  logic signed [DIFF_W-1:0]  w_q [3];
  logic [3*ID_W-1:0]         s1_ids_q, s2_ids_q;
  logic signed [SQ_W-1:0]    uu_q [3];
  logic signed [SQ_W-1:0]    vv_q [3];
  logic signed [SQ_W-1:0]    ww_q [3];
  logic signed [SQ_W-1:0]    uv_q [3];
  logic [2*DCUT_W-1:0]       cut_sq_q;
  logic [SQ_W-1:0]           usq_d, vsq_d, wsq_d;
  logic signed [DOT_W-1:0]   dot_d;
  logic                      keep_d;
  hbg_item_t                 item_q;

  assign d_c[0] = donor_x_i;
  assign d_c[1] = donor_y_i;
  assign d_c[2] = donor_z_i;
  assign h_c[0] = hydrogen_x_i;
  assign h_c[1] = hydrogen_y_i;
  assign h_c[2] = hydrogen_z_i;
  assign a_c[0] = acceptor_x_i;
  assign a_c[1] = acceptor_y_i;
  assign a_c[2] = acceptor_z_i;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      push_q   <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      push_q   <= s2_vld_q && keep_d;
    end
  end

  // stage 1: A-D, H-D, H-A; stage 2: products
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      u_q[k]  <= DIFF_W'(a_c[k]) - DIFF_W'(d_c[k]);
      v_q[k]  <= DIFF_W'(h_c[k]) - DIFF_W'(d_c[k]);
      w_q[k]  <= DIFF_W'(h_c[k]) - DIFF_W'(a_c[k]);
      uu_q[k] <= u_q[k] * u_q[k];
      vv_q[k] <= v_q[k] * v_q[k];
      ww_q[k] <= w_q[k] * w_q[k];
      uv_q[k] <= u_q[k] * v_q[k];
    end
    s1_ids_q <= {donor_id_i, hydrogen_id_i, acceptor_id_i};
    s2_ids_q <= s1_ids_q;
    cut_sq_q <= dist_cutoff_i * dist_cutoff_i;
  end

  // stage 3: sums and classification
  always_comb begin
    usq_d  = $unsigned(uu_q[0]) + $unsigned(uu_q[1]) + $unsigned(uu_q[2]);
    vsq_d  = $unsigned(vv_q[0]) + $unsigned(vv_q[1]) + $unsigned(vv_q[2]);
    wsq_d  = $unsigned(ww_q[0]) + $unsigned(ww_q[1]) + $unsigned(ww_q[2]);
    dot_d  = DOT_W'(uv_q[0]) + DOT_W'(uv_q[1]) + DOT_W'(uv_q[2]);
    keep_d = (usq_d <= SQ_W'(cut_sq_q)) && (usq_d != '0) && (vsq_d != '0);
  end

  always_ff @(posedge clk_i) begin
    item_q.usq <= usq_d;
    item_q.vsq <= vsq_d;
    item_q.wsq <= wsq_d;
    item_q.dot <= dot_d;
    {item_q.did, item_q.hid, item_q.aid} <= s2_ids_q;
  end

  assign push_o = push_q;
  assign item_o = item_q;

endmodule

### sv/hbg_fifo.sv
// Short request queue between the front end and the angle back end.
module hbg_fifo #(
  parameter int DEPTH = hbg_pkg::FIFO_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  hbg_pkg::hbg_item_t           item_i,
  output logic                         valid_o,
  output hbg_pkg::hbg_item_t           item_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);
  import hbg_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hbg_item_t          mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;

  // back end never stalls: pop whenever something is queued
  assign pop     = (count_q != '0);
  assign count_d = count_q + CNT_W'(push_i) - CNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign valid_o = pop;
  assign item_o  = mem_q[rd_q];
  assign count_o = count_q;

endmodule

### sv/hbg_back.sv
// Back end: lengths, cosine division, sine root, CORDIC angle, cutoff test and result register.
module hbg_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  hbg_pkg::hbg_item_t            item_i,
  input  logic [hbg_pkg::ACUT_W-1:0]    angle_cutoff_i,
  output logic                          done_o,
  output logic [hbg_pkg::ID_W-1:0]      out_donor_id_o,
  output logic [hbg_pkg::ID_W-1:0]      out_hydrogen_id_o,
  output logic [hbg_pkg::ID_W-1:0]      out_acceptor_id_o,
  output logic [hbg_pkg::RU_W-1:0]      da_distance_o,
  output logic [hbg_pkg::ANG_W-1:0]     bond_angle_deg_o,
  output logic [hbg_pkg::RW_W-1:0]      ha_distance_o
);
  import hbg_pkg::*;

  localparam int ROOT1_W  = SQ_W / 2;
  localparam int R_SIDE_W = DOT_W + 3 * ID_W;
  localparam int SD_W     = $bits(hbg_side_t);
  localparam logic [CM_W-1:0]        CM_ONE   = {1'b1, {CFRAC{1'b0}}};
  localparam logic [S_RAD_W-1:0]     S_ONE    = S_RAD_W'(1) << (2 * CFRAC);
  localparam logic signed [ZW-1:0]   Z_90     = ZW'(64'd90 << ANG_FRAC);
  localparam logic [ANGZ_W-1:0]      Z_180    = ANGZ_W'(64'd180 << ANG_FRAC);
  localparam logic [ANGZ_W:0]        ANG_HALF = (33'd1 << ANG_SHIFT) >> 1;
  localparam logic [ANGZ_W:0]        ANG_MAX  = (33'd1 << ANG_W) - 33'd1;

  // ---------------- lengths |A-D|, |H-D|, |H-A| ----------------
  logic [2:0][SQ_W-1:0]      r_rad;
  logic [2:0][ROOT1_W-1:0]   r_root;
  logic [R_SIDE_W-1:0]       r_side;
  logic                      r_vld;
  logic signed [DOT_W-1:0]   r_dot;
  logic [ID_W-1:0]           r_did, r_hid, r_aid;
  logic [RU_W-1:0]           ru_sat;
  logic [RW_W-1:0]           rw_sat;

  assign r_rad = {item_i.wsq, item_i.vsq, item_i.usq};

  hbg_isqrt #(.IN_W(SQ_W), .LANES(3), .SIDE_W(R_SIDE_W)) u_isqrt_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .rad_i   (r_rad),
    .side_i  ({item_i.dot, item_i.did, item_i.hid, item_i.aid}),
    .valid_o (r_vld),
    .root_o  (r_root),
    .side_o  (r_side)
  );

  assign {r_dot, r_did, r_hid, r_aid} = r_side;
  assign ru_sat = (|r_root[0][ROOT1_W-1:RU_W]) ? '1 : r_root[0][RU_W-1:0];
  assign rw_sat = (|r_root[2][ROOT1_W-1:RW_W]) ? '1 : r_root[2][RW_W-1:0];

  // ---------------- denominator and |dot| ----------------
  logic              m_vld_q;
  logic [DEN_W-1:0]  m_den_q;
  logic [SQ_W-1:0]   m_num_q;
  hbg_side_t         m_side_q;

  always_ff @(posedge clk_i) begin
    m_den_q       <= ru_sat * r_root[1];
    m_num_q       <= r_dot[DOT_W-1] ? SQ_W'(-r_dot) : SQ_W'(r_dot);
    m_side_q.did  <= r_did;
    m_side_q.hid  <= r_hid;
    m_side_q.aid  <= r_aid;
    m_side_q.neg  <= r_dot[DOT_W-1];
    m_side_q.ru   <= ru_sat;
    m_side_q.rw   <= rw_sat;
  end

  // ---------------- cosine = |dot| / den, restoring ----------------
  logic              p_vld_q, p_sat_q;
  logic [DEN_W-1:0]  p_rem_q, p_den_q;
  hbg_side_t         p_side_q;

  always_ff @(posedge clk_i) begin
    p_sat_q  <= (m_num_q >= SQ_W'(m_den_q));
    p_rem_q  <= m_num_q[DEN_W-1:0];
    p_den_q  <= m_den_q;
    p_side_q <= m_side_q;
  end

  logic [CFRAC-1:0]  dv_vld_p, dv_vld_q;
  logic [DEN_W-1:0]  dv_rem_p [CFRAC];
  logic [DEN_W-1:0]  dv_rem_d [CFRAC];
  logic [DEN_W-1:0]  dv_rem_q [CFRAC];
  logic [DEN_W-1:0]  dv_den_p [CFRAC];
  logic [DEN_W-1:0]  dv_den_q [CFRAC];
  logic [CFRAC-1:0]  dv_quo_p [CFRAC];
  logic [CFRAC-1:0]  dv_quo_d [CFRAC];
  logic [CFRAC-1:0]  dv_quo_q [CFRAC];
  logic              dv_sat_p [CFRAC];
  logic              dv_sat_q [CFRAC];
  hbg_side_t         dv_side_p [CFRAC];
  hbg_side_t         dv_side_q [CFRAC];
  logic [DEN_W:0]    dv_t [CFRAC];

  always_comb begin
    dv_vld_p[0]  = p_vld_q;
    dv_rem_p[0]  = p_rem_q;
    dv_den_p[0]  = p_den_q;
    dv_quo_p[0]  = '0;
    dv_sat_p[0]  = p_sat_q;
    dv_side_p[0] = p_side_q;
    for (int k = 1; k < CFRAC; k++) begin
      dv_vld_p[k]  = dv_vld_q[k-1];
      dv_rem_p[k]  = dv_rem_q[k-1];
      dv_den_p[k]  = dv_den_q[k-1];
      dv_quo_p[k]  = dv_quo_q[k-1];
      dv_sat_p[k]  = dv_sat_q[k-1];
      dv_side_p[k] = dv_side_q[k-1];
    end
  end

  // one quotient bit per stage
  always_comb begin
    for (int k = 0; k < CFRAC; k++) begin
      dv_t[k] = {dv_rem_p[k], 1'b0};
      if (dv_t[k] >= {1'b0, dv_den_p[k]}) begin
        dv_rem_d[k] = DEN_W'(dv_t[k] - {1'b0, dv_den_p[k]});
        dv_quo_d[k] = {dv_quo_p[k][CFRAC-2:0], 1'b1};
      end else begin
        dv_rem_d[k] = dv_t[k][DEN_W-1:0];
        dv_quo_d[k] = {dv_quo_p[k][CFRAC-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CFRAC; k++) begin
      dv_rem_q[k]  <= dv_rem_d[k];
      dv_den_q[k]  <= dv_den_p[k];
      dv_quo_q[k]  <= dv_quo_d[k];
      dv_sat_q[k]  <= dv_sat_p[k];
      dv_side_q[k] <= dv_side_p[k];
    end
  end

  // ---------------- cm and cm^2 ----------------
  logic                 c_vld_q;
  logic [CM_W-1:0]      c_cm_d, c_cm_q;
  logic [S_RAD_W-1:0]   c_cm2_q;
  hbg_side_t            c_side_q;

  assign c_cm_d = dv_sat_q[CFRAC-1] ? CM_ONE : {1'b0, dv_quo_q[CFRAC-1]};

  always_ff @(posedge clk_i) begin
    c_cm_q   <= c_cm_d;
    c_cm2_q  <= c_cm_d * c_cm_d;
    c_side_q <= dv_side_q[CFRAC-1];
  end

  // ---------------- sine magnitude s = sqrt(1 - cm^2) ----------------
  logic [0:0][S_RAD_W-1:0]   s_rad;
  logic [0:0][CM_W-1:0]      s_root;
  logic [CM_W+SD_W-1:0]      s_side;
  logic                      s_vld;
  logic [CM_W-1:0]           s_cm;
  hbg_side_t                 s_sd;

  assign s_rad[0] = S_ONE - c_cm2_q;

  hbg_isqrt #(.IN_W(S_RAD_W), .LANES(1), .SIDE_W(CM_W + SD_W)) u_isqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_vld_q),
    .rad_i   (s_rad),
    .side_i  ({c_cm_q, c_side_q}),
    .valid_o (s_vld),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign {s_cm, s_sd} = s_side;

  // ---------------- CORDIC vectoring, one step per stage ----------------
  logic [CORDIC_STEPS-1:0]   cr_vld_p, cr_vld_q;
  logic signed [XYW-1:0]     cr_x_p [CORDIC_STEPS];
  logic signed [XYW-1:0]     cr_x_q [CORDIC_STEPS];
  logic signed [XYW-1:0]     cr_y_p [CORDIC_STEPS];
  logic signed [XYW-1:0]     cr_y_q [CORDIC_STEPS];
  logic signed [ZW-1:0]      cr_z_p [CORDIC_STEPS];
  logic signed [ZW-1:0]      cr_z_q [CORDIC_STEPS];
  logic                      cr_zero_p [CORDIC_STEPS];
  logic                      cr_zero_q [CORDIC_STEPS];
  hbg_side_t                 cr_side_p [CORDIC_STEPS];
  hbg_side_t                 cr_side_q [CORDIC_STEPS];

  always_comb begin
    cr_vld_p[0]  = s_vld;
    cr_x_p[0]    = XYW'(s_cm);
    cr_y_p[0]    = XYW'(s_root[0]);
    cr_z_p[0]    = '0;
    cr_zero_p[0] = (s_root[0] == '0);
    cr_side_p[0] = s_sd;
    for (int k = 1; k < CORDIC_STEPS; k++) begin
      cr_vld_p[k]  = cr_vld_q[k-1];
      cr_x_p[k]    = cr_x_q[k-1];
      cr_y_p[k]    = cr_y_q[k-1];
      cr_z_p[k]    = cr_z_q[k-1];
      cr_zero_p[k] = cr_zero_q[k-1];
      cr_side_p[k] = cr_side_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (cr_y_p[k] >= 0) begin
        cr_x_q[k] <= cr_x_p[k] + (cr_y_p[k] >>> k);
        cr_y_q[k] <= cr_y_p[k] - (cr_x_p[k] >>> k);
        cr_z_q[k] <= cr_z_p[k] + atan_deg(k);
      end else begin
        cr_x_q[k] <= cr_x_p[k] - (cr_y_p[k] >>> k);
        cr_y_q[k] <= cr_y_p[k] + (cr_x_p[k] >>> k);
        cr_z_q[k] <= cr_z_p[k] - atan_deg(k);
      end
      cr_zero_q[k] <= cr_zero_p[k];
      cr_side_q[k] <= cr_side_p[k];
    end
  end

  // ---------------- clamp to [0, 90] and fold for negative dot ----------------
  logic                  f_vld_q;
  logic signed [ZW-1:0]  f_zc;
  logic [ANGZ_W-1:0]     f_z_d, f_z_q;
  hbg_side_t             f_side_q;

  always_comb begin
    if (cr_zero_q[CORDIC_STEPS-1] || (cr_z_q[CORDIC_STEPS-1] < 0)) begin
      f_zc = '0;
    end else if (cr_z_q[CORDIC_STEPS-1] > Z_90) begin
      f_zc = Z_90;
    end else begin
      f_zc = cr_z_q[CORDIC_STEPS-1];
    end
    f_z_d = cr_side_q[CORDIC_STEPS-1].neg ? Z_180 - ANGZ_W'(f_zc) : ANGZ_W'(f_zc);
  end

  always_ff @(posedge clk_i) begin
    f_z_q    <= f_z_d;
    f_side_q <= cr_side_q[CORDIC_STEPS-1];
  end

  // ---------------- round, angle test, result register ----------------
  logic [ANGZ_W:0]  o_ang;
  logic             o_keep;
  logic             done_q;

  assign o_ang  = ({1'b0, f_z_q} + ANG_HALF) >> ANG_SHIFT;
  assign o_keep = (o_ang <= (ANGZ_W + 1)'(angle_cutoff_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      dv_vld_q <= '0;
      c_vld_q <= 1'b0;
      cr_vld_q <= '0;
      f_vld_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      m_vld_q  <= r_vld;
      p_vld_q  <= m_vld_q;
      dv_vld_q <= dv_vld_p;
      c_vld_q  <= dv_vld_q[CFRAC-1];
      cr_vld_q <= cr_vld_p;
      f_vld_q  <= cr_vld_q[CORDIC_STEPS-1];
      done_q   <= f_vld_q && o_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    out_donor_id_o    <= f_side_q.did;
    out_hydrogen_id_o <= f_side_q.hid;
    out_acceptor_id_o <= f_side_q.aid;
    da_distance_o     <= f_side_q.ru;
    ha_distance_o     <= f_side_q.rw;
    bond_angle_deg_o  <= (o_ang > ANG_MAX) ? ANG_MAX[ANG_W-1:0] : o_ang[ANG_W-1:0];
  end

  assign done_o = done_q;

endmodule

### sv/hydrogen_bond_geometry_test_top.sv
// Top level of the hydrogen bond geometry test: config registers, front end, queue, back end.
//
//  Channel   Handshake                     Payload
//  --------  ----------------------------  ------------------------------------------
//  request   start && !busy                donor/hydrogen/acceptor x,y,z and three IDs
//  result    done_o (one-cycle strobe)     IDs, da_distance, bond_angle_deg, ha_distance
//  config    cfg_valid_i && cfg_ready_o    cfg_index_i, cfg_data_i
//
//  One request per cycle is taken while busy is low; a result passes through
//  the square-root stages (27 and 31), the 30 cosine division stages and
//  the 24 CORDIC stages. Rejected requests give no strobe.
//  busy rises only when the request queue is close to full; the result side
//  cannot stall, so in steady operation busy stays low. Reset clears all
//  valid state and loads the cutoff defaults; cfg_ready_o is always high.
module hydrogen_bond_geometry_test_top #(
  parameter int FIFO_DEPTH = hbg_pkg::FIFO_DEPTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [hbg_pkg::COORD_W-1:0]  donor_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  donor_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  donor_z_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  hydrogen_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  hydrogen_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  hydrogen_z_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  acceptor_x_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  acceptor_y_i,
  input  logic signed [hbg_pkg::COORD_W-1:0]  acceptor_z_i,
  input  logic [hbg_pkg::ID_W-1:0]            donor_id_i,
  input  logic [hbg_pkg::ID_W-1:0]            hydrogen_id_i,
  input  logic [hbg_pkg::ID_W-1:0]            acceptor_id_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [hbg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hbg_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic [hbg_pkg::ID_W-1:0]            out_donor_id_o,
  output logic [hbg_pkg::ID_W-1:0]            out_hydrogen_id_o,
  output logic [hbg_pkg::ID_W-1:0]            out_acceptor_id_o,
  output logic [hbg_pkg::RU_W-1:0]            da_distance_o,
  output logic [hbg_pkg::ANG_W-1:0]           bond_angle_deg_o,
  output logic [hbg_pkg::RW_W-1:0]            ha_distance_o
);
  import hbg_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DCUT_W-1:0]  dist_cutoff_q;
  logic [ACUT_W-1:0]  angle_cutoff_q;
  logic               accept;
  logic               push;
  hbg_item_t          push_item;
  logic               q_valid;
  hbg_item_t          q_item;
  logic [CNT_W-1:0]   q_count;

  // config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_cutoff_q  <= DIST_CUTOFF_RST;
      angle_cutoff_q <= ANGLE_CUTOFF_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_DIST_CUTOFF:  dist_cutoff_q  <= cfg_data_i[DCUT_W-1:0];
        REG_ANGLE_CUTOFF: angle_cutoff_q <= cfg_data_i[ACUT_W-1:0];
        default: ;
      endcase
    end
  end

  // leave room for every request still inside the front end
  assign busy   = (int'(q_count) > FIFO_DEPTH - FRONT_LAT - 1);
  assign accept = start && !busy;

  hbg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (accept),
    .donor_x_i     (donor_x_i),
    .donor_y_i     (donor_y_i),
    .donor_z_i     (donor_z_i),
    .hydrogen_x_i  (hydrogen_x_i),
    .hydrogen_y_i  (hydrogen_y_i),
    .hydrogen_z_i  (hydrogen_z_i),
    .acceptor_x_i  (acceptor_x_i),
    .acceptor_y_i  (acceptor_y_i),
    .acceptor_z_i  (acceptor_z_i),
    .donor_id_i    (donor_id_i),
    .hydrogen_id_i (hydrogen_id_i),
    .acceptor_id_i (acceptor_id_i),
    .dist_cutoff_i (dist_cutoff_q),
    .push_o        (push),
    .item_o        (push_item)
  );

  hbg_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .valid_o (q_valid),
    .item_o  (q_item),
    .count_o (q_count)
  );

  hbg_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .item_i            (q_item),
    .angle_cutoff_i    (angle_cutoff_q),
    .done_o            (done_o),
    .out_donor_id_o    (out_donor_id_o),
    .out_hydrogen_id_o (out_hydrogen_id_o),
    .out_acceptor_id_o (out_acceptor_id_o),
    .da_distance_o     (da_distance_o),
    .bond_angle_deg_o  (bond_angle_deg_o),
    .ha_distance_o     (ha_distance_o)
  );

endmodule
